// ===== rtl/owb_pkg.sv =====
// ---------------------------------------------------------------------------
// owb_pkg
// Types and constants shared by the one-wire bus master files.
// ---------------------------------------------------------------------------
package owb_pkg;

    localparam int TICK_W = 10;

    // command codes carried in the input tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SAMPLE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 4'd7;

    localparam logic [TICK_W-1:0] READ_RELEASE_TICKS = 10'd50;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] reset_sample_ticks;
        logic [TICK_W-1:0] reset_tail_ticks;
        logic [TICK_W-1:0] write_one_low_ticks;
        logic [TICK_W-1:0] write_zero_low_ticks;
        logic [TICK_W-1:0] write_slot_ticks;
        logic [TICK_W-1:0] read_low_ticks;
        logic [TICK_W-1:0] read_sample_ticks;
    } cfg_t;

    typedef struct packed {
        logic       rejected;
        logic [7:0] rx_byte;
        logic       presence_ok;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    // a length of zero acts as one
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] n);
        return (n == '0) ? TICK_W'(1) : n;
    endfunction

endpackage

// ===== rtl/owb_core.sv =====
// ---------------------------------------------------------------------------
// owb_core
// Bus sequencer: phase, slot timer, bit index and shift byte, one tick
// per enabled cycle.
// ---------------------------------------------------------------------------
module owb_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    tx_byte,
    input  logic                          line_level,
    input  owb_pkg::cfg_t                 cfg,
    output owb_pkg::res_t                 res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_SLOT,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REL
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [owb_pkg::TICK_W-1:0]    tick_reg, tick_next;
    logic [2:0]                    bit_reg, bit_next;
    logic [7:0]                    shift_reg, shift_next;
    logic                          pres_reg, pres_next;

    phase_t                        ph;
    logic [owb_pkg::TICK_W-1:0]    k;
    logic [2:0]                    bidx;
    logic [7:0]                    sb;
    logic                          pres_in;
    logic                          start;
    logic [owb_pkg::TICK_W-1:0]    len;
    logic [owb_pkg::TICK_W-1:0]    low_len;
    logic [owb_pkg::TICK_W:0]      k_inc;
    logic                          last;
    logic                          drv;
    logic                          done;
    logic [7:0]                    rx;

    always_comb begin
        start   = (req_type != owb_pkg::REQ_TICK) && (phase_reg == PH_IDLE);
        ph      = phase_reg;
        k       = tick_reg;
        bidx    = bit_reg;
        sb      = shift_reg;
        pres_in = pres_reg;
        if (start) begin
            k    = '0;
            bidx = '0;
            unique case (req_type)
                owb_pkg::REQ_RESET: begin
                    ph      = PH_RST_LOW;
                    pres_in = 1'b0;
                end
                owb_pkg::REQ_WRITE: begin
                    ph = PH_WR_SLOT;
                    sb = tx_byte;
                end
                default: begin
                    ph = PH_RD_LOW;
                    sb = '0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (ph)
            PH_RST_LOW:  len = owb_pkg::at_least_one(cfg.reset_low_ticks);
            PH_RST_WAIT: len = owb_pkg::at_least_one(cfg.reset_sample_ticks);
            PH_RST_TAIL: len = owb_pkg::at_least_one(cfg.reset_tail_ticks);
            PH_WR_SLOT:  len = owb_pkg::at_least_one(cfg.write_slot_ticks);
            PH_RD_LOW:   len = owb_pkg::at_least_one(cfg.read_low_ticks);
            PH_RD_WAIT:  len = owb_pkg::at_least_one(cfg.read_sample_ticks);
            default:     len = owb_pkg::at_least_one(owb_pkg::READ_RELEASE_TICKS);
        endcase
        low_len = owb_pkg::at_least_one(sb[bidx] ? cfg.write_one_low_ticks
                                                 : cfg.write_zero_low_ticks);
        k_inc   = {1'b0, k} + 1'b1;
        last    = k_inc >= {1'b0, len};
    end

    always_comb begin
        phase_next = ph;
        bit_next   = bidx;
        shift_next = sb;
        pres_next  = pres_in;
        drv        = 1'b0;
        done       = 1'b0;
        rx         = '0;
        unique case (ph)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                drv = 1'b1;
                if (last) phase_next = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                if (last) begin
                    if (line_level) begin
                        pres_next  = 1'b0;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_RST_TAIL;
                    end
                end
            end
            PH_RST_TAIL: begin
                if (last) begin
                    pres_next  = line_level;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_WR_SLOT: begin
                drv = k < low_len;
                if (last) begin
                    if (bidx == 3'd7) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        bit_next = bidx + 3'd1;
                    end
                end
            end
            PH_RD_LOW: begin
                drv = 1'b1;
                if (last) phase_next = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                if (last) begin
                    shift_next       = sb;
                    shift_next[bidx] = sb[bidx] | line_level;
                    phase_next       = PH_RD_REL;
                end
            end
            default: begin
                if (last) begin
                    if (bidx == 3'd7) begin
                        done       = 1'b1;
                        rx         = sb;
                        phase_next = PH_IDLE;
                    end else begin
                        bit_next   = bidx + 3'd1;
                        phase_next = PH_RD_LOW;
                    end
                end
            end
        endcase
        tick_next = (ph == PH_IDLE || last) ? '0 : k_inc[owb_pkg::TICK_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
        end else if (en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
        end
    end

    always_comb begin
        res.drive_low   = drv;
        res.busy_res    = phase_next != PH_IDLE;
        res.done_res    = done;
        res.presence_ok = pres_next;
        res.rx_byte     = rx;
        res.rejected    = (req_type != owb_pkg::REQ_TICK) && (phase_reg != PH_IDLE);
    end

endmodule

// ===== rtl/onewire_bus_master.sv =====
// ---------------------------------------------------------------------------
// onewire_bus_master
// One-wire bus master, open drain. Each input item is one microsecond tick
// with the sampled bus level and an optional reset, write or read command.
//
//   channel  dir  ports                        content
//   s_       in   tvalid tready tdata tuser    tick, command, bus level
//   m_       out  tvalid tready tdata          drive, status, read byte
//   cfg_     in   we index data                slot timing registers
//
// One item per cycle unless m_tready stalls; an item's result appears the
// cycle after it is accepted, set by the sequencer step and the output register.
// s_tready follows m_tready whenever the output register holds an item.
// aresetn clears the sequencer and loads the timing registers' defaults.
// ---------------------------------------------------------------------------
module onewire_bus_master (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // tx_byte[7:0], line_level[8]
    input  logic [1:0]                    s_tuser,   // req_type[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_low[0], busy_res[1], done_res[2], presence_ok[3], rx_byte[11:4],
    // rejected[12]
    output logic [15:0]                   m_tdata,
    input  logic                          cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owb_pkg::TICK_W-1:0]    cfg_data
);

    owb_pkg::cfg_t cfg_reg;
    owb_pkg::res_t res;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;
    logic          s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks      <= 10'd500;
            cfg_reg.reset_sample_ticks   <= 10'd60;
            cfg_reg.reset_tail_ticks     <= 10'd480;
            cfg_reg.write_one_low_ticks  <= 10'd6;
            cfg_reg.write_zero_low_ticks <= 10'd60;
            cfg_reg.write_slot_ticks     <= 10'd70;
            cfg_reg.read_low_ticks       <= 10'd2;
            cfg_reg.read_sample_ticks    <= 10'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                owb_pkg::REG_RESET_LOW:    cfg_reg.reset_low_ticks      <= cfg_data;
                owb_pkg::REG_RESET_SAMPLE: cfg_reg.reset_sample_ticks   <= cfg_data;
                owb_pkg::REG_RESET_TAIL:   cfg_reg.reset_tail_ticks     <= cfg_data;
                owb_pkg::REG_WRITE_ONE:    cfg_reg.write_one_low_ticks  <= cfg_data;
                owb_pkg::REG_WRITE_ZERO:   cfg_reg.write_zero_low_ticks <= cfg_data;
                owb_pkg::REG_WRITE_SLOT:   cfg_reg.write_slot_ticks     <= cfg_data;
                owb_pkg::REG_READ_LOW:     cfg_reg.read_low_ticks       <= cfg_data;
                owb_pkg::REG_READ_SAMPLE:  cfg_reg.read_sample_ticks    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    owb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (s_accept),
        .req_type   (s_tuser),
        .tx_byte    (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'b000, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted item not presented");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
        else $error("done item still busy");

    a_rx_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11:4] != 8'd0) |-> m_tdata[2])
        else $error("read byte outside done item");

endmodule

// ===== sim/tb_onewire_bus_master.sv =====
// ---------------------------------------------------------------------------
// tb_onewire_bus_master
// Self-checking bench for the one-wire bus master. Every tick item sent in
// is run through a cycle-exact model of the reset, write and read sequencer
// and the predicted status word is compared field by field with the item
// that comes out. Covers default, zero and small slot timings, a maximum
// low time, presence outcomes, rejected commands and random traffic with
// random bus levels and random idling on both channels.
// ---------------------------------------------------------------------------
module tb_onewire_bus_master;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL,
        SEQ_WR_SLOT, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REL
    } seq_phase_t;

    typedef logic [owb_pkg::TICK_W-1:0]    tick_t;
    typedef logic [owb_pkg::CFG_IDX_W-1:0] idx_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [15:0]                   s_tdata = '0;
    logic [1:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [15:0]                   m_tdata;
    logic                          cfg_we = 1'b0;
    logic [owb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [owb_pkg::TICK_W-1:0]    cfg_data = '0;

    // model state
    owb_pkg::cfg_t timing = {10'd500, 10'd60, 10'd480, 10'd6, 10'd60, 10'd70, 10'd2, 10'd10};
    seq_phase_t    seq_phase = SEQ_IDLE;
    int            slot_tick = 0;
    logic [2:0]    bit_pos = '0;
    logic [7:0]    shift_reg = '0;
    logic          presence_q = 1'b0;

    owb_pkg::res_t bus_status_q[$];
    int   errors = 0;
    int   ticks_sent = 0;
    int   tx_calm = 0;
    int   rx_calm = 0;
    int   stall_left = 0;

    onewire_bus_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int min_one(input logic [owb_pkg::TICK_W-1:0] n);
        return (n == '0) ? 1 : int'(n);
    endfunction

    function automatic int phase_len(input seq_phase_t ph);
        case (ph)
            SEQ_RST_LOW:  return min_one(timing.reset_low_ticks);
            SEQ_RST_WAIT: return min_one(timing.reset_sample_ticks);
            SEQ_RST_TAIL: return min_one(timing.reset_tail_ticks);
            SEQ_WR_SLOT:  return min_one(timing.write_slot_ticks);
            SEQ_RD_LOW:   return min_one(timing.read_low_ticks);
            SEQ_RD_WAIT:  return min_one(timing.read_sample_ticks);
            default:      return min_one(owb_pkg::READ_RELEASE_TICKS);
        endcase
    endfunction

    // one sequencer tick: returns the status word and advances the model
    function automatic owb_pkg::res_t bus_tick(input logic [1:0] req, input logic [7:0] tx,
                                               input logic lvl);
        owb_pkg::res_t r;
        logic          last;
        int            low;
        seq_phase_t    nxt;
        r = '0;
        if (req != owb_pkg::REQ_TICK) begin
            if (seq_phase != SEQ_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                slot_tick = 0;
                bit_pos = '0;
                case (req)
                    owb_pkg::REQ_RESET: begin
                        seq_phase = SEQ_RST_LOW;
                        presence_q = 1'b0;
                    end
                    owb_pkg::REQ_WRITE: begin
                        seq_phase = SEQ_WR_SLOT;
                        shift_reg = tx;
                    end
                    default: begin
                        seq_phase = SEQ_RD_LOW;
                        shift_reg = '0;
                    end
                endcase
            end
        end
        if (seq_phase != SEQ_IDLE) begin
            last = (slot_tick + 1 >= phase_len(seq_phase));
            nxt = seq_phase;
            case (seq_phase)
                SEQ_RST_LOW: begin
                    r.drive_low = 1'b1;
                    if (last) nxt = SEQ_RST_WAIT;
                end
                SEQ_RST_WAIT: begin
                    if (last && lvl) begin
                        presence_q = 1'b0;
                        r.done_res = 1'b1;
                        nxt = SEQ_IDLE;
                    end else if (last) begin
                        nxt = SEQ_RST_TAIL;
                    end
                end
                SEQ_RST_TAIL: begin
                    if (last) begin
                        presence_q = lvl;
                        r.done_res = 1'b1;
                        nxt = SEQ_IDLE;
                    end
                end
                SEQ_WR_SLOT: begin
                    low = min_one(shift_reg[bit_pos] ? timing.write_one_low_ticks
                                                     : timing.write_zero_low_ticks);
                    r.drive_low = (slot_tick < low);
                    if (last && bit_pos == 3'd7) begin
                        r.done_res = 1'b1;
                        nxt = SEQ_IDLE;
                    end else if (last) begin
                        bit_pos = bit_pos + 3'd1;
                    end
                end
                SEQ_RD_LOW: begin
                    r.drive_low = 1'b1;
                    if (last) nxt = SEQ_RD_WAIT;
                end
                SEQ_RD_WAIT: begin
                    if (last) begin
                        shift_reg[bit_pos] = shift_reg[bit_pos] | lvl;
                        nxt = SEQ_RD_REL;
                    end
                end
                default: begin
                    if (last && bit_pos == 3'd7) begin
                        r.done_res = 1'b1;
                        r.rx_byte = shift_reg;
                        nxt = SEQ_IDLE;
                    end else if (last) begin
                        bit_pos = bit_pos + 3'd1;
                        nxt = SEQ_RD_LOW;
                    end
                end
            endcase
            slot_tick = last ? 0 : slot_tick + 1;
            seq_phase = nxt;
        end
        r.busy_res = (seq_phase != SEQ_IDLE);
        r.presence_ok = presence_q;
        return r;
    endfunction

    // mostly no gap, some short, a few long, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2) begin
            calm = $urandom_range(80, 20);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(12, 4);
    endfunction

    function automatic logic [owb_pkg::TICK_W-1:0] rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 80) return tick_t'($urandom_range(6, 1));
        return tick_t'($urandom_range(20, 7));
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        owb_pkg::res_t got;
        owb_pkg::res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[12:0];
                if (bus_status_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = bus_status_q.pop_front();
                    compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
                    compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    compare_field("presence_ok", 8'(want.presence_ok),
                                  8'(got.presence_ok));
                    compare_field("rx_byte", want.rx_byte, got.rx_byte);
                    compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
                    compare_field("pad", 8'd0, 8'(m_tdata[15:13]));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    owb_pkg::REG_RESET_LOW:    timing.reset_low_ticks = cfg_data;
                    owb_pkg::REG_RESET_SAMPLE: timing.reset_sample_ticks = cfg_data;
                    owb_pkg::REG_RESET_TAIL:   timing.reset_tail_ticks = cfg_data;
                    owb_pkg::REG_WRITE_ONE:    timing.write_one_low_ticks = cfg_data;
                    owb_pkg::REG_WRITE_ZERO:   timing.write_zero_low_ticks = cfg_data;
                    owb_pkg::REG_WRITE_SLOT:   timing.write_slot_ticks = cfg_data;
                    owb_pkg::REG_READ_LOW:     timing.read_low_ticks = cfg_data;
                    owb_pkg::REG_READ_SAMPLE:  timing.read_sample_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                bus_status_q.push_back(bus_tick(s_tuser, s_tdata[7:0], s_tdata[8]));
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left <= pick_gap(rx_calm);
        end
    end

    // noise_pct: chance that a plain tick carries a random command instead
    task automatic send_tick(input logic [1:0] req, input logic [7:0] tx, input logic lvl,
                             input int noise_pct);
        int gap;
        if (req == owb_pkg::REQ_TICK && $urandom_range(99) < noise_pct)
            req = 2'($urandom_range(3, 1));
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {7'd0, lvl, tx};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
        gap = pick_gap(tx_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_sender();
        s_tvalid <= 1'b0;
    endtask

    // tick until the sequencer is idle, then wait for every status item
    task automatic finish_commands();
        hold_sender();
        @(posedge aclk);
        while (seq_phase != SEQ_IDLE)
            send_tick(owb_pkg::REQ_TICK, 8'($urandom), 1'($urandom_range(1)), 0);
        hold_sender();
        do @(posedge aclk); while (bus_status_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [owb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owb_pkg::TICK_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic load_timing(input owb_pkg::cfg_t t);
        logic [owb_pkg::CFG_IDX_W-1:0] junk_idx;
        junk_idx = idx_t'($urandom_range(15, 8));
        finish_commands();
        put_reg(owb_pkg::REG_RESET_LOW, t.reset_low_ticks);
        put_reg(owb_pkg::REG_RESET_SAMPLE, t.reset_sample_ticks);
        put_reg(owb_pkg::REG_RESET_TAIL, t.reset_tail_ticks);
        put_reg(owb_pkg::REG_WRITE_ONE, t.write_one_low_ticks);
        put_reg(owb_pkg::REG_WRITE_ZERO, t.write_zero_low_ticks);
        put_reg(owb_pkg::REG_WRITE_SLOT, t.write_slot_ticks);
        put_reg(owb_pkg::REG_READ_LOW, t.read_low_ticks);
        put_reg(owb_pkg::REG_READ_SAMPLE, t.read_sample_ticks);
        put_reg(junk_idx, tick_t'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // whole reset sequence; bus level given at the presence and tail samples
    task automatic run_reset(input logic first_lvl, input logic tail_lvl, input int noise_pct);
        int sample_at;
        int last_at;
        sample_at = min_one(timing.reset_low_ticks) + min_one(timing.reset_sample_ticks) - 1;
        last_at = first_lvl ? sample_at : sample_at + min_one(timing.reset_tail_ticks);
        for (int i = 0; i <= last_at; i++)
            send_tick(i == 0 ? owb_pkg::REQ_RESET : owb_pkg::REQ_TICK, 8'($urandom),
                      i == sample_at ? first_lvl :
                      (i == last_at ? tail_lvl : 1'($urandom_range(1))), noise_pct);
    endtask

    task automatic run_write(input logic [7:0] bus_byte, input int noise_pct);
        int n;
        n = 8 * min_one(timing.write_slot_ticks);
        for (int i = 0; i < n; i++)
            send_tick(i == 0 ? owb_pkg::REQ_WRITE : owb_pkg::REQ_TICK,
                      i == 0 ? bus_byte : 8'($urandom),
                      1'($urandom_range(1)), noise_pct);
    endtask

    task automatic run_read(input logic [7:0] bus_byte, input int noise_pct);
        int rl;
        int rs;
        int per;
        rl = min_one(timing.read_low_ticks);
        rs = min_one(timing.read_sample_ticks);
        per = rl + rs + min_one(owb_pkg::READ_RELEASE_TICKS);
        for (int i = 0; i < 8 * per; i++)
            send_tick(i == 0 ? owb_pkg::REQ_READ : owb_pkg::REQ_TICK, 8'($urandom),
                      (i % per == rl + rs - 1) ? bus_byte[i / per]
                                               : 1'($urandom_range(1)),
                      noise_pct);
    endtask

    task automatic test_defaults();
        run_read(8'h3C, 0);
    endtask

    task automatic test_zero_lengths();
        load_timing('0);
        run_reset(1'b1, 1'b0, 0);
        run_write(8'hFF, 0);
        run_write(8'h00, 0);
        run_read(8'hA5, 0);
    endtask

    task automatic test_low_beyond_slot();
        load_timing({10'd3, 10'd4, 10'd5, 10'd9, 10'd1023, 10'd3, 10'd1, 10'd2});
        run_write(8'h5A, 0);
        load_timing({10'd1, 10'd1, 10'd1, 10'd1023, 10'd2, 10'd2, 10'd1, 10'd1});
        run_write(8'hC3, 0);
    endtask

    task automatic test_presence();
        load_timing({10'd3, 10'd4, 10'd5, 10'd1, 10'd2, 10'd4, 10'd2, 10'd3});
        run_reset(1'b0, 1'b1, 0);
        run_reset(1'b1, 1'b1, 0);
        run_reset(1'b0, 1'b1, 0);
        run_write(8'h69, 0);
        run_reset(1'b0, 1'b0, 0);
    endtask

    task automatic test_busy_rejects();
        load_timing({10'd1, 10'd2, 10'd1, 10'd2, 10'd3, 10'd4, 10'd1, 10'd1});
        run_write(8'h96, 100);
        run_reset(1'b0, 1'b1, 100);
        run_write(8'h01, 0);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int kind;
        for (int p = 0; p < 3; p++) begin
            load_timing({rand_len(), rand_len(), rand_len(), rand_len(),
                         rand_len(), rand_len(), rand_len(), rand_len()});
            stop_at = ticks_sent + 150;
            while (ticks_sent < stop_at) begin
                kind = $urandom_range(99);
                repeat ($urandom_range(3, 0))
                    send_tick(owb_pkg::REQ_TICK, 8'($urandom), 1'($urandom_range(1)), 0);
                if (kind < 8) begin
                    repeat ($urandom_range(40, 10))
                        send_tick(2'($urandom_range(3, 0)), 8'($urandom),
                                  1'($urandom_range(1)), 0);
                    finish_commands();
                end else if (kind < 45) begin
                    run_reset($urandom_range(99) < 25, $urandom_range(99) < 80, 3);
                end else if (kind < 88) begin
                    run_write(8'($urandom), 3);
                end else begin
                    run_read(8'($urandom), 3);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_zero_lengths();
        test_low_beyond_slot();
        test_presence();
        test_busy_rejects();
        test_random_traffic();
        finish_commands();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/owb_pkg.sv
rtl/owb_core.sv
rtl/onewire_bus_master.sv
sim/tb_onewire_bus_master.sv
